// File: rtl/spl_pkg.sv
// Shared constants, types and helpers of the stereo peak level meter.
package spl_pkg;

	localparam int HISTORY_DEPTH = 5;
	localparam int SAMPLE_W      = 16;
	localparam int LEVEL_W       = 16;
	localparam int PEAK_W        = 16;
	localparam int LEN_W         = 13;
	localparam int COUNT_W       = 12;
	localparam int PEAK_MAX      = 32768;

	localparam logic [LEN_W-1:0] WINDOW_RESET = 13'd100;
	localparam logic [LEN_W-1:0] WINDOW_MAX   = 13'd4096;

	localparam int FILL_W   = $clog2(HISTORY_DEPTH + 1);
	localparam int PTR_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int SUM_W    = $clog2(HISTORY_DEPTH * PEAK_MAX + 1);
	localparam int DIVCNT_W = $clog2(SUM_W + 1);

	// power of two, pointers wrap on their own
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic              channel;
		logic [PEAK_W-1:0] peak;
	} spl_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} spl_qstat_t;

	// |s| with -32768 giving 32768 (fits unsigned 16 bits)
	function automatic logic [PEAK_W-1:0] magnitude(input logic [SAMPLE_W-1:0] s);
		logic [PEAK_W-1:0] neg;
		neg = ~s + 16'd1;
		return s[SAMPLE_W-1] ? neg : s;
	endfunction

endpackage

// File: rtl/spl_front.sv
// Front end: window length register, per-channel peak tracking and window end detection.
module spl_front import spl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [LEN_W-1:0]    cfg_data,
	input  logic                push,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                channel,
	input  spl_qstat_t          q_stat,
	output logic                q_push,
	output spl_word_t           q_word
);

	logic [LEN_W-1:0]   window_length_q;
	logic [PEAK_W-1:0]  peak_q [2];
	logic [COUNT_W-1:0] count_q [2];

	logic               accept;
	logic [PEAK_W-1:0]  mag;
	logic [PEAK_W-1:0]  pk_cur;
	logic [PEAK_W-1:0]  pk_new;
	logic [LEN_W-1:0]   cnt_inc;
	logic [LEN_W-1:0]   eff_len;
	logic               done;

	always_comb begin
		accept  = push && !q_stat.full;
		mag     = magnitude(sample);
		pk_cur  = peak_q[channel];
		pk_new  = (mag > pk_cur) ? mag : pk_cur;
		cnt_inc = {1'b0, count_q[channel]} + 13'd1;
		priority if (window_length_q == '0) begin
			eff_len = 13'd1;
		end else if (window_length_q > WINDOW_MAX) begin
			eff_len = WINDOW_MAX;
		end else begin
			eff_len = window_length_q;
		end
		done           = (cnt_inc >= eff_len);
		q_push         = accept && done;
		q_word.channel = channel;
		q_word.peak    = pk_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_RESET;
			peak_q[0]       <= '0;
			peak_q[1]       <= '0;
			count_q[0]      <= '0;
			count_q[1]      <= '0;
		end else begin
			if (cfg_write) begin
				window_length_q <= cfg_data;
			end
			if (accept) begin
				if (done) begin
					peak_q[channel]  <= '0;
					count_q[channel] <= '0;
				end else begin
					peak_q[channel]  <= pk_new;
					count_q[channel] <= cnt_inc[COUNT_W-1:0];
				end
			end
		end
	end

endmodule

// File: rtl/spl_queue.sv
// Short word queue between the front end and the averaging back end.
module spl_queue import spl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  spl_word_t  word_in,
	input  logic       pop,
	output spl_word_t  word_out,
	output spl_qstat_t stat
);

	spl_word_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	always_comb begin
		stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
		stat.empty = (cnt_q == '0);
		do_push    = push && !stat.full;
		do_pop     = pop && !stat.empty;
		word_out   = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("front end pushed into a full queue");

endmodule

// File: rtl/spl_back.sv
// Back end: peak history, running sum, serial divider and result register.
module spl_back import spl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  spl_qstat_t         q_stat,
	input  spl_word_t          q_word,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic               out_channel,
	output logic [LEVEL_W-1:0] level
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [PEAK_W-1:0]   hist_q [2][HISTORY_DEPTH];
	logic [SUM_W-1:0]    sum_q  [2];
	logic [FILL_W-1:0]   fill_q [2];
	logic [PTR_W-1:0]    ptr_q  [2];

	logic [SUM_W-1:0]    quo_q;
	logic [FILL_W-1:0]   rem_q;
	logic [FILL_W-1:0]   dvs_q;
	logic [DIVCNT_W-1:0] cnt_q;
	logic                ch_q;

	logic                out_valid_q;
	logic                out_channel_q;
	logic [LEVEL_W-1:0]  level_q;

	logic                take;
	logic                hc;
	logic                hist_full;
	logic [PEAK_W-1:0]   old_peak;
	logic [SUM_W-1:0]    sum_new;
	logic [FILL_W-1:0]   fill_new;
	logic [PTR_W-1:0]    ptr_new;
	logic [FILL_W:0]     part;
	logic [FILL_W:0]     part_sub;
	logic                ge;
	logic                out_free;
	logic                load_out;

	always_comb begin
		take      = (state_q == ST_IDLE) && !q_stat.empty;
		q_pop     = take;
		hc        = q_word.channel;
		hist_full = (fill_q[hc] == FILL_W'(HISTORY_DEPTH));
		// evicted peak leaves the sum once the history wraps
		old_peak  = hist_full ? hist_q[hc][ptr_q[hc]] : '0;
		sum_new   = sum_q[hc] - SUM_W'(old_peak) + SUM_W'(q_word.peak);
		fill_new  = hist_full ? fill_q[hc] : fill_q[hc] + 1'b1;
		ptr_new   = (ptr_q[hc] == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_q[hc] + 1'b1;

		// restoring divide, one quotient bit per cycle
		part      = {rem_q, quo_q[SUM_W-1]};
		part_sub  = part - {1'b0, dvs_q};
		ge        = (part >= {1'b0, dvs_q});

		out_free  = !out_valid_q || pop;
		load_out  = (state_q == ST_DONE) && out_free;

		empty       = !out_valid_q;
		out_channel = out_channel_q;
		level       = level_q;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			hist_q[hc][ptr_q[hc]] <= q_word.peak;
			quo_q                 <= sum_new;
			rem_q                 <= '0;
			dvs_q                 <= fill_new;
			ch_q                  <= hc;
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= ge ? part_sub[FILL_W-1:0] : part[FILL_W-1:0];
		end
		if (load_out) begin
			level_q       <= quo_q[LEVEL_W-1:0];
			out_channel_q <= ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			sum_q[0]    <= '0;
			sum_q[1]    <= '0;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			ptr_q[0]    <= '0;
			ptr_q[1]    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						sum_q[hc]  <= sum_new;
						fill_q[hc] <= fill_new;
						ptr_q[hc]  <= ptr_new;
						cnt_q      <= '0;
						state_q    <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIVCNT_W'(SUM_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= FILL_W'(HISTORY_DEPTH)) && (fill_q[1] <= FILL_W'(HISTORY_DEPTH)))
		else $error("history fill beyond depth");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (quo_q <= SUM_W'(PEAK_MAX)))
		else $error("mean above largest peak");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_DONE) |-> $past(cnt_q) == DIVCNT_W'(SUM_W - 1))
		else $error("divider left early");

endmodule

// File: rtl/stereo_peak_level_meter_unit.sv
// Top level of the stereo peak level meter.
//
// Input words carry one signed 16-bit PCM sample and its channel (0 left,
// 1 right). A word is taken on a clock edge with push high and full low.
// Each channel counts its own samples; after window_length samples of a
// channel (0 acts as 1, above 4096 as 4096) that window's peak magnitude
// goes into a five-deep history and a result word is produced: the channel
// and the truncated mean of the valid history peaks.
// Results come out like a queue: while empty is low the oldest result sits
// on out_channel/level and leaves on an edge with pop high.
// cfg_write/cfg_data load window_length (reset 100); write only while idle.
//
// Throughput: the front end takes one sample per cycle while its 4-word
// queue has room. Each window end keeps the back end busy through the
// one-bit-per-cycle mean divider; no new word is taken until its result
// is loaded, so full rises when windows end faster than it clears them.
// Path: window peak, queue, history and sum, divider, result register.
// Stall: with pop low the result register holds; the back end then waits,
// the queue fills and full goes high. Reset clears peaks, counts, history
// fill and all queues; history contents need no clearing.
module stereo_peak_level_meter_unit import spl_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [LEN_W-1:0]           cfg_data,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       channel,
	input  logic                       pop,
	output logic                       empty,
	output logic                       out_channel,
	output logic [LEVEL_W-1:0]         level
);

	spl_qstat_t q_stat;
	spl_word_t  f_word;
	spl_word_t  b_word;
	logic       f_push;
	logic       b_pop;

	// window peaks per channel
	spl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.push      (push),
		.sample    (sample),
		.channel   (channel),
		.q_stat    (q_stat),
		.q_push    (f_push),
		.q_word    (f_word)
	);

	// decouples sample intake from the slow averaging
	spl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_push),
		.word_in  (f_word),
		.pop      (b_pop),
		.word_out (b_word),
		.stat     (q_stat)
	);

	// history, mean and result register
	spl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_word      (b_word),
		.q_pop       (b_pop),
		.pop         (pop),
		.empty       (empty),
		.out_channel (out_channel),
		.level       (level)
	);

	assign full = q_stat.full;

endmodule

// File: tb/stereo_peak_level_meter_unit_test.sv
// Self-checking testbench for the stereo peak level meter: a scoreboard model checks every result word.
`timescale 1ns / 1ps

module stereo_peak_level_meter_unit_test import spl_pkg::*;;

	// Margin after the last result before the next register write.
	localparam int SETTLE_CYCLES = 60;
	// Watchdog: cycles in a row with no word moving on either side.
	localparam int STALL_LIMIT   = 4000;
	localparam int BURST_MAX     = 18;

	typedef struct packed {
		logic               ch;
		logic [LEVEL_W-1:0] level;
	} level_word_t;

	// Scoreboard: keeps its own copy of the per-channel window state and
	// queues one expected level word per window end.
	class level_scoreboard;
		logic [LEN_W-1:0]  window_len;
		int unsigned       peak [2];
		int unsigned       taken [2];
		int unsigned       hist [2][HISTORY_DEPTH];
		int unsigned       fill [2];
		int unsigned       slot [2];
		level_word_t       level_q [$];
		int                errors;

		function new();
			window_len = WINDOW_RESET;
			errors     = 0;
			for (int c = 0; c < 2; c++) begin
				peak[c]  = 0;
				taken[c] = 0;
				fill[c]  = 0;
				slot[c]  = 0;
			end
		endfunction

		function void set_window(logic [LEN_W-1:0] v);
			window_len = v;
		endfunction

		// 0 behaves as 1, anything past 4096 as 4096
		function int unsigned window_span();
			if (window_len == 0)
				return 1;
			if (window_len > WINDOW_MAX)
				return WINDOW_MAX;
			return window_len;
		endfunction

		function int pending();
			return level_q.size();
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		function void note_sample(logic signed [SAMPLE_W-1:0] s, logic ch);
			int          v;
			int unsigned mag;
			int unsigned total;
			level_word_t w;
			v   = s;
			mag = (v < 0) ? -v : v;
			if (mag > peak[ch])
				peak[ch] = mag;
			taken[ch]++;
			if (taken[ch] < window_span())
				return;
			hist[ch][slot[ch]] = peak[ch];
			slot[ch] = (slot[ch] + 1 == HISTORY_DEPTH) ? 0 : slot[ch] + 1;
			if (fill[ch] < HISTORY_DEPTH)
				fill[ch]++;
			total = 0;
			for (int i = 0; i < fill[ch]; i++)
				total += hist[ch][i];
			w.ch    = ch;
			w.level = LEVEL_W'(total / fill[ch]);
			level_q = {level_q, w};
			peak[ch]  = 0;
			taken[ch] = 0;
		endfunction

		task check_result(logic ch, logic [LEVEL_W-1:0] lvl);
			level_word_t w;
			if (level_q.size() == 0) begin
				report($sformatf("result ch=%0d level=%0d with nothing expected", ch, lvl));
				return;
			end
			w = level_q.pop_front();
			if (ch !== w.ch)
				report($sformatf("out_channel %0d, expected %0d", ch, w.ch));
			if (lvl !== w.level)
				report($sformatf("level %0d, expected %0d (ch %0d)", lvl, w.level, w.ch));
		endtask

		task check_drained();
			if (level_q.size() != 0)
				report($sformatf("%0d expected level words never came", level_q.size()));
		endtask
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_write = 1'b0;
	logic [LEN_W-1:0]           cfg_data = '0;
	logic                       push = 1'b0;
	logic                       full;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       channel = 1'b0;
	logic                       pop = 1'b0;
	logic                       empty;
	logic                       out_channel;
	logic [LEVEL_W-1:0]         level;

	level_scoreboard sb = new();

	// 1-in-N odds of an idle burst per word; 0 turns idling off
	int push_odds = 6;
	int pop_odds  = 6;
	int quiet_cycles = 0;

	always #6 clk = ~clk;

	stereo_peak_level_meter_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.push       (push),
		.full       (full),
		.sample     (sample),
		.channel    (channel),
		.pop        (pop),
		.empty      (empty),
		.out_channel(out_channel),
		.level      (level)
	);

	// Monitors: both sides sampled on the rising edge. A word pushed on this
	// edge can't produce a result on the same edge, so order doesn't matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_result(out_channel, level);
			if (push && !full)
				sb.note_sample(sample, channel);
		end
	end

	// Watchdog on cycles where nothing moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Result side: pop held high, with random stall bursts.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (pop_odds != 0 && $urandom_range(1, pop_odds) == 1) begin
				n = $urandom_range(1, BURST_MAX);
				pop <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Drive one word and hold it until the block takes it.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic ch);
		int n;
		@(negedge clk);
		if (push_odds != 0 && $urandom_range(1, push_odds) == 1) begin
			n = $urandom_range(1, BURST_MAX);
			push <= 1'b0;
			repeat (n) @(negedge clk);
		end
		push    <= 1'b1;
		sample  <= s;
		channel <= ch;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Mix of full-range values, corners and near-silence.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		logic signed [SAMPLE_W-1:0] corners [5];
		corners = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
		unique case ($urandom_range(0, 9))
			0: begin
				return corners[$urandom_range(0, 4)];
			end
			1: begin
				return SAMPLE_W'($signed($urandom_range(0, 127)) - 64);
			end
			default: begin
				return SAMPLE_W'($urandom);
			end
		endcase
	endfunction

	// left_pct: percent chance a word goes to channel 0
	task automatic run_random(input int items, input int left_pct);
		logic ch;
		for (int i = 0; i < items; i++) begin
			ch = ($urandom_range(0, 99) < left_pct) ? 1'b0 : 1'b1;
			send_sample(pick_sample(), ch);
		end
	endtask

	// Push side goes quiet, every result drains, then the back end settles.
	task automatic wait_idle();
		@(negedge clk);
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write while idle; window counts carry over, so a new length
	// lands mid-window on purpose.
	task automatic write_window(input logic [LEN_W-1:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.set_window(v);
		push_odds = $urandom_range(2, 12);
		pop_odds  = $urandom_range(2, 12);
	endtask

	initial begin
		logic signed [SAMPLE_W-1:0] corner_vals [12];
		corner_vals = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1, -16'sd32767,
			16'sh5555, 16'shAAAA, 16'sd16384, -16'sd16384, 16'sh7FFE, 16'sh8001};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset length of 100, never written yet
		run_random(300, 50);
		wait_idle();

		// Directed: one-sample windows, corner values on both channels; six or
		// more windows per channel so the history wraps and drops the oldest.
		write_window(13'd1);
		for (int i = 0; i < 24; i++)
			send_sample(corner_vals[i % 12], ((i / 3) % 2 == 1) ^ (i >= 12));
		wait_idle();

		// zero acts as a one-sample window
		write_window(13'd0);
		run_random(120, 50);
		wait_idle();

		write_window(13'd3);
		run_random(150, 30);
		wait_idle();

		// Above the maximum: 4096 in effect, so no window ends in this stretch.
		write_window(13'h1FFF);
		run_random(60, 99);
		wait_idle();

		// exact maximum; again no window end
		write_window(WINDOW_MAX);
		run_random(40, 50);
		wait_idle();

		// both counts already at or past 2: next sample of each ends its window
		write_window(13'd2);
		run_random(150, 50);
		wait_idle();

		write_window(13'd17);
		run_random(150, 60);
		wait_idle();

		write_window(13'd5);
		run_random(100, 50);
		wait_idle();

		// last stretch at full rate on both sides
		write_window(13'd6);
		push_odds = 0;
		pop_odds  = 0;
		run_random(200, 50);
		wait_idle();

		sb.check_drained();
		if (sb.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
